/* src/mqlw_pkg.sv */
package mqlw_pkg;

  localparam int COORD_W      = 16;
  localparam int SLOT_W       = 10;
  localparam int VERTEX_DEPTH = 1024;
  localparam int AXIS_W       = 5;
  localparam int MAX_QUADS_AXIS = 31;
  localparam int QIDX_W       = 10;
  localparam int WEIGHT_W     = 17;
  localparam int SQ_W         = 35;   // exact squared distance, integer coordinate units squared
  localparam int ROOT_W       = 26;   // floor(sqrt(sq * 2^16))
  localparam int RAD_W        = 52;   // sq, 16 zero bits, one pad bit
  localparam int RREM_W       = 29;   // square root remainder
  localparam int DSUM_W       = 28;   // sum of four distances
  localparam int DREM_W       = 29;   // division remainder
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_QUADS_ACROSS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUADS_DOWN   = 2'd1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CROSS,
    ST_DIST_MUL,
    ST_DIST_SUM,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

/* src/mqlw_if.sv */
interface mqlw_in_if import mqlw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [SLOT_W-1:0]         vertex_index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

interface mqlw_out_if import mqlw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [QIDX_W-1:0]   quad_index;
  logic [WEIGHT_W-1:0] weight_a;
  logic [WEIGHT_W-1:0] weight_b;
  logic [WEIGHT_W-1:0] weight_c;
  logic [WEIGHT_W-1:0] weight_d;

  modport source (output valid, found, quad_index, weight_a, weight_b, weight_c, weight_d,
                  input ready);
  modport sink   (input valid, found, quad_index, weight_a, weight_b, weight_c, weight_d,
                  output ready);
endinterface

interface mqlw_cfg_if import mqlw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [AXIS_W-1:0]    data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

/* src/mesh_quad_locate_and_weights_unit.sv */
// Quad mesh point locator with distance weights.
// in_ch carries transactions of two kinds: a load (action 0) writes one
// vertex {y, x} into the vertex memory at vertex_index and gives no result;
// a query (action 1) gives one result on out_ch. cfg writes quads_across
// (index 0) and quads_down (index 1); it is always ready.
// A query scans quads in row-major order; each quad takes four reads on the
// single memory read port, then four cross products pipelined through two
// 17x17 multipliers. A hit adds four distances (iterative square root, one
// bit a cycle) and four divisions.
// Items are handled one at a time; in_ch.ready is high only between queries.
// A finished result sits in an output register, so a new item is taken while
// out_ch stalls; a later query then waits at its end until that register
// frees up.
// Reset clears control and sets both registers to 1. The vertex memory is
// not cleared; a query must only touch loaded slots.
module mesh_quad_locate_and_weights_unit import mqlw_pkg::*; (
  input logic        clk,
  input logic        rst,
  mqlw_in_if.sink    in_ch,
  mqlw_out_if.source out_ch,
  mqlw_cfg_if.sink   cfg
);

  state_t state, state_next;

  logic [AXIS_W-1:0] quads_across, quads_down;

  logic [31:0] mem [VERTEX_DEPTH];
  logic [31:0] rd_data;
  logic [SLOT_W-1:0] rd_addr;

  logic signed [COORD_W-1:0] px, py;
  logic signed [COORD_W-1:0] cx [4];
  logic signed [COORD_W-1:0] cy [4];

  logic [AXIS_W-1:0] gx, gy;
  logic [SLOT_W-1:0] base;
  logic [QIDX_W-1:0] qidx;
  logic [2:0]        cnt;
  logic [1:0]        sel_q;
  logic              pass;

  logic signed [33:0] prod1, prod2;
  logic [1:0]         dn;
  logic [4:0]         div_cnt;
  logic [ROOT_W-1:0]  dlen [4];
  logic [DSUM_W-1:0]  dsum;
  logic [DREM_W-1:0]  drem;
  logic [WEIGHT_W-2:0] dq;
  logic [WEIGHT_W-1:0] wt [4];
  logic               hit;

  logic               out_valid;

  logic [SLOT_W:0] stride;
  logic            in_acc;
  logic            last_col, last_row;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg.ready   = 1'b1;
  assign stride      = (SLOT_W+1)'(quads_across) + 1'b1;
  assign last_col    = (gx == quads_across - 1'b1);
  assign last_row    = (gy == quads_down - 1'b1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quads_across <= AXIS_W'(1);
      quads_down   <= AXIS_W'(1);
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_QUADS_ACROSS: quads_across <= (cfg.data > AXIS_W'(MAX_QUADS_AXIS)) ?
                                          AXIS_W'(MAX_QUADS_AXIS) : cfg.data;
        REG_QUADS_DOWN:   quads_down   <= (cfg.data > AXIS_W'(MAX_QUADS_AXIS)) ?
                                          AXIS_W'(MAX_QUADS_AXIS) : cfg.data;
        default: ;
      endcase
    end
  end

  // corner slot address for the read in flight
  always_comb begin
    logic [SLOT_W:0] a;
    a = (SLOT_W+1)'(base) + (SLOT_W+1)'(gx);
    case (cnt[1:0])
      2'd0:    rd_addr = SLOT_W'(a);
      2'd1:    rd_addr = SLOT_W'(a + stride);
      2'd2:    rd_addr = SLOT_W'(a + stride + 1'b1);
      default: rd_addr = SLOT_W'(a + 1'b1);
    endcase
  end

  // vertex memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.action == ACT_LOAD) begin
      mem[in_ch.vertex_index] <= {in_ch.coord_y, in_ch.coord_x};
    end
    rd_data <= mem[rd_addr];
  end

  // edge products for the cross test selected by cnt
  logic signed [COORD_W:0] dvx, dvy, dpx, dpy;
  always_comb begin
    logic [1:0] u, v;
    case (cnt[1:0])
      2'd0:    begin u = 2'd0; v = 2'd1; end
      2'd1:    begin u = 2'd0; v = 2'd3; end
      2'd2:    begin u = 2'd1; v = 2'd2; end
      default: begin u = 2'd2; v = 2'd3; end
    endcase
    dvx = (COORD_W+1)'(cx[v]) - (COORD_W+1)'(cx[u]);
    dvy = (COORD_W+1)'(cy[v]) - (COORD_W+1)'(cy[u]);
    dpx = (COORD_W+1)'(px) - (COORD_W+1)'(cx[u]);
    dpy = (COORD_W+1)'(py) - (COORD_W+1)'(cy[u]);
  end

  logic signed [34:0] cr;
  logic               cr_ok;
  assign cr    = 35'(prod1) - 35'(prod2);
  assign cr_ok = (sel_q == 2'd1) ? !cr[34] : (cr[34] || cr == '0);

  // distance terms
  logic signed [COORD_W:0] ex, ey;
  logic [SQ_W-1:0]         sq_sum;
  assign ex     = (COORD_W+1)'(px) - (COORD_W+1)'(cx[dn]);
  assign ey     = (COORD_W+1)'(py) - (COORD_W+1)'(cy[dn]);
  assign sq_sum = SQ_W'(unsigned'(prod1)) + SQ_W'(unsigned'(prod2));

  logic [ROOT_W-1:0] root;
  sqrt_stat_t        sq_stat;
  logic              sq_start;
  assign sq_start = (state == ST_DIST_SUM);

  mqlw_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .sq    (sq_sum),
    .root  (root),
    .stat  (sq_stat)
  );

  // division step: first step compares d itself, later ones the doubled rest
  logic [DREM_W-1:0] dtrial;
  logic              dge;
  assign dtrial = (div_cnt == '0) ? drem : {drem[DREM_W-2:0], 1'b0};
  assign dge    = dtrial >= DREM_W'(dsum);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_ch.action == ACT_QUERY) begin
          state_next = (quads_across == '0 || quads_down == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ:  if (cnt == 3'd4) state_next = ST_CROSS;
      ST_CROSS: begin
        if (cnt == 3'd4) begin
          if (pass && cr_ok)               state_next = ST_DIST_MUL;
          else if (last_col && last_row)   state_next = ST_DONE;
          else                             state_next = ST_READ;
        end
      end
      ST_DIST_MUL: state_next = ST_DIST_SUM;
      ST_DIST_SUM: state_next = ST_SQRT;
      ST_SQRT: begin
        if (sq_stat.done) begin
          if (dn != 2'd3)                              state_next = ST_DIST_MUL;
          else if ((dsum + DSUM_W'(root)) == '0)       state_next = ST_DONE;
          else                                         state_next = ST_DIV;
        end
      end
      ST_DIV:  if (div_cnt == 5'd16 && dn == 2'd3) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // scan and arithmetic datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      hit <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          px   <= in_ch.coord_x;
          py   <= in_ch.coord_y;
          gx   <= '0;
          gy   <= '0;
          base <= '0;
          qidx <= '0;
          cnt  <= '0;
          hit  <= 1'b0;
          dn   <= '0;
          dsum <= '0;
          for (int i = 0; i < 4; i++) wt[i] <= '0;
        end
        ST_READ: begin
          if (cnt != 3'd0) begin
            cx[cnt[1:0] - 2'd1] <= rd_data[15:0];
            cy[cnt[1:0] - 2'd1] <= rd_data[31:16];
          end
          cnt  <= (cnt == 3'd4) ? 3'd0 : cnt + 3'd1;
          pass <= 1'b1;
        end
        ST_CROSS: begin
          prod1 <= dvx * dpy;
          prod2 <= dvy * dpx;
          sel_q <= cnt[1:0];
          if (cnt != 3'd0) pass <= pass && cr_ok;
          if (cnt == 3'd4) begin
            cnt <= '0;
            if (pass && cr_ok) begin
              hit <= 1'b1;
            end else begin
              qidx <= qidx + 1'b1;
              if (last_col) begin
                gx   <= '0;
                gy   <= gy + 1'b1;
                base <= SLOT_W'((SLOT_W+1)'(base) + stride);
              end else begin
                gx <= gx + 1'b1;
              end
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_DIST_MUL: begin
          prod1 <= ex * ex;
          prod2 <= ey * ey;
        end
        ST_SQRT: begin
          if (sq_stat.done) begin
            dlen[dn] <= root;
            dsum     <= dsum + DSUM_W'(root);
            dn       <= dn + 2'd1;
            div_cnt  <= '0;
            drem     <= DREM_W'(dlen[0]);
          end
        end
        ST_DIV: begin
          dq <= {dq[WEIGHT_W-3:0], dge};
          if (div_cnt == 5'd16) begin
            wt[dn]  <= {dq, dge};
            dn      <= dn + 2'd1;
            div_cnt <= '0;
            drem    <= DREM_W'(dlen[dn + 2'd1]);
          end else begin
            drem    <= dge ? (dtrial - DREM_W'(dsum)) : dtrial;
            div_cnt <= div_cnt + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (state == ST_DONE && (!out_valid || out_ch.ready)) begin
        out_valid         <= 1'b1;
        out_ch.found      <= hit;
        out_ch.quad_index <= hit ? qidx : '0;
        out_ch.weight_a   <= hit ? wt[0] : '0;
        out_ch.weight_b   <= hit ? wt[1] : '0;
        out_ch.weight_c   <= hit ? wt[2] : '0;
        out_ch.weight_d   <= hit ? wt[3] : '0;
      end
    end
  end

  assign out_ch.valid = out_valid;

  // checks
  a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> state == ST_SQRT)
    else $error("square root finished outside its state");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> dsum != '0)
    else $error("division started with zero distance sum");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.found) |-> (out_ch.quad_index == '0 &&
      out_ch.weight_a == '0 && out_ch.weight_b == '0 &&
      out_ch.weight_c == '0 && out_ch.weight_d == '0))
    else $error("miss result carries nonzero fields");

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.action == ACT_QUERY) |=> state != ST_IDLE)
    else $error("query accepted but scan did not start");

endmodule

/* src/mqlw_isqrt.sv */
// Restoring integer square root of (sq << 16), one result bit per cycle.
module mqlw_isqrt import mqlw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   sq,
  output logic [ROOT_W-1:0] root,
  output sqrt_stat_t        stat
);

  logic [RAD_W-1:0]  rad;
  logic [RREM_W-1:0] rem;
  logic [4:0]        cnt;
  logic              busy;
  logic              done;

  logic [RREM_W-1:0] rem_sh;
  logic [RREM_W-1:0] trial;
  logic              ge;

  // one digit pair per step
  always_comb begin
    rem_sh = {rem[RREM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = RREM_W'({root, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(ROOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  // datapath; the pad bit sits on top so digit pairs line up with the value
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {1'b0, sq, 16'd0};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* verif/tb_mesh_quad_locate_and_weights_unit.sv */
`timescale 1ns / 100ps

module tb_mesh_quad_locate_and_weights_unit;
  import mqlw_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct packed {
    logic                found;
    logic [QIDX_W-1:0]   quad_index;
    logic [WEIGHT_W-1:0] weight_a;
    logic [WEIGHT_W-1:0] weight_b;
    logic [WEIGHT_W-1:0] weight_c;
    logic [WEIGHT_W-1:0] weight_d;
  } locate_result_t;

  logic clk;
  logic rst;

  mqlw_in_if  in_ch();
  mqlw_out_if out_ch();
  mqlw_cfg_if cfg();

  mesh_quad_locate_and_weights_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // Predictor state: vertex memory copy and mesh size
  logic [31:0]       mesh_mem [VERTEX_DEPTH];
  logic [AXIS_W-1:0] mesh_across;
  logic [AXIS_W-1:0] mesh_down;

  locate_result_t pending_results [$];
  int             fail_count;
  int             query_count;
  int             load_count;
  int             result_count;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             quiet_cycles;

  // Grid geometry of the current mesh
  int grid_base;
  int grid_step;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint edge_side(longint ux, longint uy, longint vx, longint vy,
                                       longint px, longint py);
    return (vx - ux) * (py - uy) - (vy - uy) * (px - ux);
  endfunction

  // Scan quads row-major; the first quad that passes every edge test wins
  function automatic locate_result_t locate_point(logic signed [COORD_W-1:0] qx,
                                                  logic signed [COORD_W-1:0] qy);
    locate_result_t  res;
    longint          cx [4];
    longint          cy [4];
    longint unsigned dlen [4];
    longint unsigned dsum;
    longint          px;
    longint          py;
    longint          ex;
    longint          ey;
    int              stride;
    int              slot;
    bit              hit;
    int              hit_idx;
    res = '0;
    px = qx;
    py = qy;
    stride = mesh_across + 1;
    hit = 0;
    hit_idx = 0;
    for (int gy = 0; gy < mesh_down && !hit; gy++) begin
      for (int gx = 0; gx < mesh_across && !hit; gx++) begin
        for (int n = 0; n < 4; n++) begin
          // corner order A(0,0) B(0,1) C(1,1) D(1,0)
          slot = (gy + ((n == 1 || n == 2) ? 1 : 0)) * stride + gx + ((n >= 2) ? 1 : 0);
          cx[n] = $signed(mesh_mem[slot][15:0]);
          cy[n] = $signed(mesh_mem[slot][31:16]);
        end
        if (edge_side(cx[0], cy[0], cx[1], cy[1], px, py) <= 0 &&
            edge_side(cx[0], cy[0], cx[3], cy[3], px, py) >= 0 &&
            edge_side(cx[1], cy[1], cx[2], cy[2], px, py) <= 0 &&
            edge_side(cx[2], cy[2], cx[3], cy[3], px, py) <= 0) begin
          hit = 1;
          hit_idx = gy * mesh_across + gx;
        end
      end
    end
    if (!hit) return res;
    dsum = 0;
    for (int n = 0; n < 4; n++) begin
      ex = px - cx[n];
      ey = py - cy[n];
      dlen[n] = int_sqrt((longint'(ex * ex) + longint'(ey * ey)) << 16);
      dsum += dlen[n];
    end
    res.found = 1'b1;
    res.quad_index = hit_idx[QIDX_W-1:0];
    if (dsum != 0) begin
      res.weight_a = WEIGHT_W'((dlen[0] << 16) / dsum);
      res.weight_b = WEIGHT_W'((dlen[1] << 16) / dsum);
      res.weight_c = WEIGHT_W'((dlen[2] << 16) / dsum);
      res.weight_d = WEIGHT_W'((dlen[3] << 16) / dsum);
    end
    return res;
  endfunction

  // Send one transaction; an optional gap first, valid left high afterwards
  task automatic send_item(logic act, logic [SLOT_W-1:0] idx,
                           logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.vertex_index <= idx;
    in_ch.coord_x      <= x;
    in_ch.coord_y      <= y;
    do @(posedge clk); while (!in_ch.ready);
    if (act == ACT_LOAD) begin
      mesh_mem[idx] = {y, x};
      load_count++;
    end else begin
      pending_results.push_back(locate_point(x, y));
      query_count++;
    end
  endtask

  task automatic load_vertex(int idx, int x, int y);
    send_item(ACT_LOAD, SLOT_W'(idx), COORD_W'(x), COORD_W'(y));
  endtask

  task automatic query_point(int x, int y);
    send_item(ACT_QUERY, SLOT_W'($urandom), COORD_W'(x), COORD_W'(y));
  endtask

  // Drop valid, wait out all results, then let the last load settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AXIS_W-1:0] value);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.data      <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_QUADS_ACROSS) mesh_across = value;
    else if (idx == REG_QUADS_DOWN) mesh_down = value;
  endtask

  task automatic set_mesh_size(int across, int down);
    drain_results();
    write_reg(REG_QUADS_ACROSS, AXIS_W'(across));
    write_reg(REG_QUADS_DOWN, AXIS_W'(down));
  endtask

  // Regular grid with jitter; every vertex slot of the mesh gets loaded
  task automatic load_grid();
    int jit;
    grid_step = $urandom_range(40, 1000);
    grid_base = -16000;
    for (int gy = 0; gy <= mesh_down; gy++) begin
      for (int gx = 0; gx <= mesh_across; gx++) begin
        jit = grid_step / 4;
        load_vertex(gy * (mesh_across + 1) + gx,
                    grid_base + gx * grid_step + int'($urandom_range(2 * jit)) - jit,
                    grid_base + gy * grid_step + int'($urandom_range(2 * jit)) - jit);
      end
    end
  endtask

  // One random query: mostly inside the mesh, some on vertices, some far off
  task automatic random_query();
    int pick;
    int slot;
    pick = $urandom_range(99);
    if (pick < 60) begin
      query_point(grid_base + int'($urandom_range(mesh_across * grid_step)),
                  grid_base + int'($urandom_range(mesh_down * grid_step)));
    end else if (pick < 75) begin
      slot = $urandom_range((mesh_across + 1) * (mesh_down + 1) - 1);
      query_point($signed(mesh_mem[slot][15:0]), $signed(mesh_mem[slot][31:16]));
    end else if (pick < 85) begin
      query_point(grid_base - 1 - int'($urandom_range(400)),
                  grid_base + int'($urandom_range(mesh_down * grid_step)));
    end else begin
      query_point($signed(16'($urandom)), $signed(16'($urandom)));
    end
  endtask

  // Stray load to a slot outside the live mesh, full-range coordinates
  task automatic stray_load();
    int idx;
    idx = $urandom_range((mesh_across + 1) * (mesh_down + 1), VERTEX_DEPTH - 1);
    load_vertex(idx, $signed(16'($urandom)), $signed(16'($urandom)));
  endtask

  task automatic test_extreme_quad();
    set_mesh_size(1, 1);
    load_vertex(0, -32768, -32768);
    load_vertex(1, 32767, -32768);
    load_vertex(2, -32768, 32767);
    load_vertex(3, 32767, 32767);
    query_point(0, 0);
    query_point(-32768, -32768);
    query_point(32767, 32767);
    query_point(-32768, 32767);
    query_point(32767, -32768);
    query_point(1234, -20000);
  endtask

  // All four corners collapsed to one point: zero distance sum at that point
  task automatic test_collapsed_quad();
    for (int n = 0; n < 4; n++) load_vertex(n, 80, -48);
    query_point(80, -48);
    query_point(-5, 7);
    load_vertex(VERTEX_DEPTH - 1, -1, -1);
    load_vertex(0, -100, -100);
    query_point(80, -48);
  endtask

  // A zero register leaves an empty mesh; unknown index is ignored
  task automatic test_empty_mesh();
    set_mesh_size(0, 1);
    query_point(0, 0);
    set_mesh_size(1, 0);
    query_point(100, 100);
    drain_results();
    write_reg(2'd2, 5'd7);
    write_reg(2'd3, 5'd31);
    write_reg(REG_QUADS_DOWN, 5'd1);
    query_point(80, -48);
  endtask

  task automatic test_mesh_walk(int across, int down, int queries);
    set_mesh_size(across, down);
    load_grid();
    for (int i = 0; i < queries; i++) begin
      if ($urandom_range(9) == 0) stray_load();
      random_query();
    end
  endtask

  // Result check and receiver stall
  always @(posedge clk) begin
    locate_result_t want;
    locate_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.found, out_ch.quad_index, out_ch.weight_a, out_ch.weight_b,
             out_ch.weight_c, out_ch.weight_d};
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found)
          $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
        if (got.quad_index !== want.quad_index)
          $display("%0t: quad_index exp %0d got %0d", $time, want.quad_index,
                   got.quad_index);
        if (got.weight_a !== want.weight_a)
          $display("%0t: weight_a exp %0d got %0d", $time, want.weight_a, got.weight_a);
        if (got.weight_b !== want.weight_b)
          $display("%0t: weight_b exp %0d got %0d", $time, want.weight_b, got.weight_b);
        if (got.weight_c !== want.weight_c)
          $display("%0t: weight_c exp %0d got %0d", $time, want.weight_c, got.weight_c);
        if (got.weight_d !== want.weight_d)
          $display("%0t: weight_d exp %0d got %0d", $time, want.weight_d, got.weight_d);
        if (got !== want) fail_count++;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD;
    in_ch.vertex_index = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    cfg.valid = 1'b0;
    cfg.reg_index = REG_QUADS_ACROSS;
    cfg.data = '0;
    mesh_across = 1;
    mesh_down = 1;
    fail_count = 0;
    query_count = 0;
    load_count = 0;
    result_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_quad();
    test_collapsed_quad();
    test_empty_mesh();

    send_idle_pct = 56;
    test_mesh_walk(3, 2, 10);
    // sender holds off until the block has emptied
    drain_results();
    test_mesh_walk(31, 1, 6);

    send_idle_pct = 0;
    recv_stall_pct = 56;
    test_mesh_walk(1, 4, 6);

    send_idle_pct = 19;
    recv_stall_pct = 19;
    test_mesh_walk(2, 2, 8);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    $display("covered %0d loads and %0d queries, %0d results checked", load_count,
             query_count, result_count);
    $display("mesh sizes from empty to 31 quads per row, with sender and receiver stalls");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
